### rtl/rgps_pkg.sv
// Shared types and constants for the radial gradient parameter solver.
`default_nettype none

package rgps_pkg;

	// Configuration register index width and register map
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_CX  = 3'd0,
		REG_START_CY  = 3'd1,
		REG_START_R   = 3'd2,
		REG_END_CX    = 3'd3,
		REG_END_CY    = 3'd4,
		REG_END_R     = 3'd5,
		REG_EXT_BEFORE = 3'd6,
		REG_EXT_AFTER = 3'd7
	} cfg_reg_t;

	// Per-stage control handed to every cell of a chain
	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

endpackage

`default_nettype wire

### rtl/rgps_if.sv
// Stream interfaces for sample points, results and configuration writes.
`default_nettype none

interface rgps_point_if #(parameter int COORD_BITS = 32) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

interface rgps_result_if #(parameter int COORD_BITS = 32) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] t_value;
	logic                         hit;

	modport source (output valid, output t_value, output hit, input ready);
	modport sink (input valid, input t_value, input hit, output ready);
endinterface

interface rgps_cfg_if
	import rgps_pkg::*;
	#(parameter int COORD_BITS = 32) ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [COORD_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/rgps_sqrt_cell.sv
// One digit cell of the pipelined integer square root chain (two radicand bits per cell).
`default_nettype none

module rgps_sqrt_cell
	import rgps_pkg::*;
#(
	parameter int SW   = 8,
	parameter int PAYW = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stage_ctl_t        ctl_i,
	input  wire logic [2*SW-1:0]   rad_i,
	input  wire logic [SW+1:0]     rem_i,
	input  wire logic [SW-1:0]     root_i,
	input  wire logic [PAYW-1:0]   pay_i,
	output logic                   valid_o,
	output logic [2*SW-1:0]        rad_o,
	output logic [SW+1:0]          rem_o,
	output logic [SW-1:0]          root_o,
	output logic [PAYW-1:0]        pay_o
);

	logic [SW+3:0] rem_x;
	logic [SW+3:0] trial;
	logic          ge;
	logic [SW+3:0] rem_d;

	// Bring down the next radicand bit pair and try the next root bit
	always_comb begin
		rem_x = {rem_i, rad_i[2*SW-1 -: 2]};
		trial = (SW+4)'({root_i, 2'b01});
		ge    = (rem_x >= trial);
		rem_d = ge ? (rem_x - trial) : rem_x;
	end

	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl_i.en) begin
			valid_s1 <= ctl_i.valid;
		end
	end

	logic [2*SW-1:0] rad_s1;
	logic [SW+1:0]   rem_s1;
	logic [SW-1:0]   root_s1;
	logic [PAYW-1:0] pay_s1;

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			rad_s1  <= rad_i << 2;
			rem_s1  <= rem_d[SW+1:0];
			root_s1 <= (SW)'({root_i, ge});
			pay_s1  <= pay_i;
		end
	end

	assign valid_o = valid_s1;
	assign rad_o   = rad_s1;
	assign rem_o   = rem_s1;
	assign root_o  = root_s1;
	assign pay_o   = pay_s1;

endmodule

`default_nettype wire

### rtl/rgps_div_cell.sv
// One quotient-bit cell of the two-lane restoring divider chain.
`default_nettype none

module rgps_div_cell
	import rgps_pkg::*;
#(
	parameter int NW   = 16,
	parameter int DVW  = 8,
	parameter int PAYW = 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire stage_ctl_t             ctl_i,
	input  wire logic [1:0][NW-1:0]     num_i,
	input  wire logic [1:0][DVW-1:0]    den_i,
	input  wire logic [1:0][DVW-1:0]    rem_i,
	input  wire logic [1:0][NW-1:0]     quo_i,
	input  wire logic [PAYW-1:0]        pay_i,
	output logic                        valid_o,
	output logic [1:0][NW-1:0]          num_o,
	output logic [1:0][DVW-1:0]         den_o,
	output logic [1:0][DVW-1:0]         rem_o,
	output logic [1:0][NW-1:0]          quo_o,
	output logic [PAYW-1:0]             pay_o
);

	logic [1:0][DVW:0]   rem_x;
	logic [1:0]          ge;
	logic [1:0][DVW:0]   rem_d;

	// Shift in the next numerator bit, subtract the divisor if it fits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rem_x[l] = {rem_i[l], num_i[l][NW-1]};
			ge[l]    = (rem_x[l] >= {1'b0, den_i[l]});
			rem_d[l] = ge[l] ? (rem_x[l] - {1'b0, den_i[l]}) : rem_x[l];
		end
	end

	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl_i.en) begin
			valid_s1 <= ctl_i.valid;
		end
	end

	logic [1:0][NW-1:0]  num_s1;
	logic [1:0][DVW-1:0] den_s1;
	logic [1:0][DVW-1:0] rem_s1;
	logic [1:0][NW-1:0]  quo_s1;
	logic [PAYW-1:0]     pay_s1;

	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			for (int l = 0; l < 2; l++) begin
				num_s1[l] <= num_i[l] << 1;
				den_s1[l] <= den_i[l];
				rem_s1[l] <= rem_d[l][DVW-1:0];
				quo_s1[l] <= (NW)'({quo_i[l], ge[l]});
			end
			pay_s1 <= pay_i;
		end
	end

	assign valid_o = valid_s1;
	assign num_o   = num_s1;
	assign den_o   = den_s1;
	assign rem_o   = rem_s1;
	assign quo_o   = quo_s1;
	assign pay_o   = pay_s1;

endmodule

`default_nettype wire

### rtl/radial_gradient_param_solve.sv
// Top level: two-point conical gradient solver, quadratic front end, root and divider chains.
// Throughput: one point per cycle unless a full output buffer with no taker stalls the input;
// every stage, square root cell and divider cell is pipelined.
// Depth is set by the square root chain (2*COORD_BITS+7 cells) and the divider chain
// (2*COORD_BITS+FRAC_BITS+11 cells); a two-entry output buffer keeps input open while a result waits.
// Reset: arst_n clears all valid bits and the output buffer; configuration registers return to their defaults.
`default_nettype none

module radial_gradient_param_solve
	import rgps_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	rgps_point_if.sink      point,
	rgps_result_if.source   result,
	rgps_cfg_if.sink        cfg
);

	localparam int C   = COORD_BITS;
	localparam int W   = C + 1;
	localparam int PW  = 2 * C + 6;
	localparam int H   = PW / 2;
	localparam int DW  = 2 * PW + 3;
	localparam int SW  = PW + 1;
	localparam int MW  = PW + 3;
	localparam int NW  = MW + FRAC_BITS + 2;
	localparam int DVW = PW + 2;
	localparam int RTW = NW + 1;

	localparam logic signed [PW-1:0]  EPS_P   = PW'(1) <<< FRAC_BITS;
	localparam logic signed [DW-1:0]  EPS_D   = DW'(1) <<< (3 * FRAC_BITS);
	localparam logic signed [RTW-1:0] UNIT_R  = RTW'(1) <<< FRAC_BITS;
	localparam logic signed [RTW-1:0] HI_R    = UNIT_R + RTW'(1);
	localparam logic signed [RTW-1:0] LO_R    = -RTW'(1);
	localparam logic signed [RTW-1:0] LIMHI_R = (RTW'(1) <<< (C - 1)) - RTW'(1);
	localparam logic signed [RTW-1:0] LIMLO_R = -(RTW'(1) <<< (C - 1));

	typedef struct packed {
		logic signed [PW:0] x0;
		logic signed [PW:0] nb;
		logic signed [PW:0] d0;
		logic signed [PW:0] d1;
		logic               lin;
		logic               flag;
		logic               in_end;
	} sqp_t;

	typedef struct packed {
		logic neg0;
		logic neg1;
		logic lin;
		logic dead;
		logic in_end;
	} dvp_t;

	localparam int SQPW = $bits(sqp_t);
	localparam int DVPW = $bits(dvp_t);

	// ---------------------------------------------------------------- config
	logic [C-1:0] scx_q, scy_q, ecx_q, ecy_q;
	logic [C-2:0] sr_q, er_q;
	logic         eb_q, ea_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scx_q <= '0;
			scy_q <= '0;
			sr_q  <= '0;
			ecx_q <= '0;
			ecy_q <= '0;
			er_q  <= (C-1)'(1) << FRAC_BITS;
			eb_q  <= 1'b0;
			ea_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_START_CX: begin
					scx_q <= cfg.data;
				end
				REG_START_CY: begin
					scy_q <= cfg.data;
				end
				REG_START_R: begin
					sr_q <= cfg.data[C-2:0];
				end
				REG_END_CX: begin
					ecx_q <= cfg.data;
				end
				REG_END_CY: begin
					ecy_q <= cfg.data;
				end
				REG_END_R: begin
					er_q <= cfg.data[C-2:0];
				end
				REG_EXT_BEFORE: begin
					eb_q <= cfg.data[0];
				end
				REG_EXT_AFTER: begin
					ea_q <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	logic       en;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign en          = (cnt_q != 2'd2) || result.ready;
	assign point.ready = en;

	// ---------------------------------------------------------------- valid bits of front stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic sq_v [0:SW];
	logic dv_v [0:NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= point.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= sq_v[SW];
			v_s8 <= dv_v[NW];
			v_s9 <= v_s8;
		end
	end

	// ---------------------------------------------------------------- s1: differences
	logic signed [W-1:0] pdx_s1, pdy_s1, dcx_s1, dcy_s1, r0_s1, dr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pdx_s1 <= $signed({scx_q[C-1], scx_q}) - $signed({point.point_x[C-1], point.point_x});
			pdy_s1 <= $signed({scy_q[C-1], scy_q}) - $signed({point.point_y[C-1], point.point_y});
			dcx_s1 <= $signed({ecx_q[C-1], ecx_q}) - $signed({scx_q[C-1], scx_q});
			dcy_s1 <= $signed({ecy_q[C-1], ecy_q}) - $signed({scy_q[C-1], scy_q});
			r0_s1  <= $signed({2'b00, sr_q});
			dr_s1  <= $signed({2'b00, er_q}) - $signed({2'b00, sr_q});
		end
	end

	// ---------------------------------------------------------------- s2: products
	logic signed [2*W-1:0] pxc_s2, pyc_s2, r0dr_s2, pxx_s2, pyy_s2, r0r0_s2;
	logic signed [2*W-1:0] cxx_s2, cyy_s2, drdr_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s2  <= pdx_s1 * dcx_s1;
			pyc_s2  <= pdy_s1 * dcy_s1;
			r0dr_s2 <= r0_s1 * dr_s1;
			pxx_s2  <= pdx_s1 * pdx_s1;
			pyy_s2  <= pdy_s1 * pdy_s1;
			r0r0_s2 <= r0_s1 * r0_s1;
			cxx_s2  <= dcx_s1 * dcx_s1;
			cyy_s2  <= dcy_s1 * dcy_s1;
			drdr_s2 <= dr_s1 * dr_s1;
		end
	end

	// ---------------------------------------------------------------- s3: quadratic coefficients
	logic signed [PW-1:0] a_s3, b_s3, c_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= PW'(cxx_s2) + PW'(cyy_s2) - PW'(drdr_s2);
			b_s3 <= (PW'(pxc_s2) + PW'(pyc_s2) - PW'(r0dr_s2)) <<< 1;
			c_s3 <= PW'(pxx_s2) + PW'(pyy_s2) - PW'(r0r0_s2);
		end
	end

	// ---------------------------------------------------------------- s4: partial products, case flags
	logic signed [H:0]    bh, bl, ah, al, ch, cl;
	logic                 lin_n, blin_n, inside_n;
	logic signed [PW+1:0] abc_n;
	sqp_t                 fr_n;

	always_comb begin
		bh       = $signed({b_s3[PW-1], b_s3[PW-1:H]});
		bl       = $signed({1'b0, b_s3[H-1:0]});
		ah       = $signed({a_s3[PW-1], a_s3[PW-1:H]});
		al       = $signed({1'b0, a_s3[H-1:0]});
		ch       = $signed({c_s3[PW-1], c_s3[PW-1:H]});
		cl       = $signed({1'b0, c_s3[H-1:0]});
		lin_n    = (a_s3 > -EPS_P) && (a_s3 < EPS_P);
		blin_n   = (b_s3 > -EPS_P) && (b_s3 < EPS_P);
		abc_n    = (PW+2)'(a_s3) + (PW+2)'(b_s3) + (PW+2)'(c_s3);
		inside_n = (abc_n <= (PW+2)'(EPS_P));
		fr_n.x0     = lin_n ? -(PW+1)'(c_s3) : -(PW+1)'(b_s3);
		fr_n.nb     = -(PW+1)'(b_s3);
		fr_n.d0     = lin_n ? (PW+1)'(b_s3) : ((PW+1)'(a_s3) <<< 1);
		fr_n.d1     = (PW+1)'(a_s3) <<< 1;
		fr_n.lin    = lin_n;
		fr_n.flag   = blin_n;
		fr_n.in_end = inside_n;
	end

	logic signed [2*H+1:0] bhh_s4, bhl_s4, bll_s4, ahch_s4, ahcl_s4, alch_s4, alcl_s4;
	sqp_t                  fr_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bhh_s4  <= bh * bh;
			bhl_s4  <= bh * bl;
			bll_s4  <= bl * bl;
			ahch_s4 <= ah * ch;
			ahcl_s4 <= ah * cl;
			alch_s4 <= al * ch;
			alcl_s4 <= al * cl;
			fr_s4   <= fr_n;
		end
	end

	// ---------------------------------------------------------------- s5: b*b and a*c
	logic signed [DW-1:0] bsq_s5, ac_s5;
	sqp_t                 fr_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s5 <= (DW'(bhh_s4) <<< (2 * H)) + (DW'(bhl_s4) <<< (H + 1)) + DW'(bll_s4);
			ac_s5  <= (DW'(ahch_s4) <<< (2 * H)) + ((DW'(ahcl_s4) + DW'(alch_s4)) <<< H)
				+ DW'(alcl_s4);
			fr_s5  <= fr_s4;
		end
	end

	// ---------------------------------------------------------------- s6: discriminant
	logic signed [DW-1:0] disc_n;
	sqp_t                 sq_pay_n;

	always_comb begin
		disc_n        = bsq_s5 - (ac_s5 <<< 2);
		sq_pay_n      = fr_s5;
		sq_pay_n.flag = fr_s5.lin ? fr_s5.flag : (disc_n < -EPS_D);
	end

	logic [2*SW-1:0] rad_s6;
	sqp_t            sqp_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s6 <= disc_n[DW-1] ? '0 : disc_n[2*SW-1:0];
			sqp_s6 <= sq_pay_n;
		end
	end

	// ---------------------------------------------------------------- square root chain
	logic [2*SW-1:0] sq_rad  [0:SW];
	logic [SW+1:0]   sq_rem  [0:SW];
	logic [SW-1:0]   sq_root [0:SW];
	logic [SQPW-1:0] sq_pay  [0:SW];

	assign sq_v[0]    = v_s6;
	assign sq_rad[0]  = rad_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_pay[0]  = sqp_s6;

	for (genvar k = 0; k < SW; k++) begin : g_sqrt
		stage_ctl_t ctl;
		assign ctl.en    = en;
		assign ctl.valid = sq_v[k];

		rgps_sqrt_cell #(
			.SW   (SW),
			.PAYW (SQPW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_i   (ctl),
			.rad_i   (sq_rad[k]),
			.rem_i   (sq_rem[k]),
			.root_i  (sq_root[k]),
			.pay_i   (sq_pay[k]),
			.valid_o (sq_v[k+1]),
			.rad_o   (sq_rad[k+1]),
			.rem_o   (sq_rem[k+1]),
			.root_o  (sq_root[k+1]),
			.pay_o   (sq_pay[k+1])
		);
	end

	// ---------------------------------------------------------------- s7: root numerators, divider setup
	sqp_t                 sqo;
	logic signed [MW-1:0] s_ext, n0, n1;
	logic [MW-1:0]        n0m, n1m;
	logic [PW:0]          d0m, d1m;
	dvp_t                 dvp_n;

	always_comb begin
		sqo         = sqp_t'(sq_pay[SW]);
		s_ext       = $signed({2'b00, sq_root[SW]});
		n0          = MW'(sqo.x0) - (sqo.lin ? MW'(0) : s_ext);
		n1          = MW'(sqo.nb) + s_ext;
		n0m         = n0[MW-1] ? MW'(-n0) : MW'(n0);
		n1m         = n1[MW-1] ? MW'(-n1) : MW'(n1);
		d0m         = sqo.d0[PW] ? (PW+1)'(-sqo.d0) : (PW+1)'(sqo.d0);
		d1m         = sqo.d1[PW] ? (PW+1)'(-sqo.d1) : (PW+1)'(sqo.d1);
		dvp_n.neg0  = n0[MW-1] ^ sqo.d0[PW];
		dvp_n.neg1  = n1[MW-1] ^ sqo.d1[PW];
		dvp_n.lin   = sqo.lin;
		dvp_n.dead  = sqo.flag;
		dvp_n.in_end = sqo.in_end;
	end

	logic [1:0][NW-1:0]  num_s7;
	logic [1:0][DVW-1:0] den_s7;
	dvp_t                dvp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s7[0] <= (NW'(n0m) << (FRAC_BITS + 1)) + NW'(d0m);
			num_s7[1] <= (NW'(n1m) << (FRAC_BITS + 1)) + NW'(d1m);
			den_s7[0] <= {d0m, 1'b0};
			den_s7[1] <= {d1m, 1'b0};
			dvp_s7    <= dvp_n;
		end
	end

	// ---------------------------------------------------------------- divider chain
	logic [1:0][NW-1:0]  dv_num [0:NW];
	logic [1:0][DVW-1:0] dv_den [0:NW];
	logic [1:0][DVW-1:0] dv_rem [0:NW];
	logic [1:0][NW-1:0]  dv_quo [0:NW];
	logic [DVPW-1:0]     dv_pay [0:NW];

	assign dv_v[0]   = v_s7;
	assign dv_num[0] = num_s7;
	assign dv_den[0] = den_s7;
	assign dv_rem[0] = '0;
	assign dv_quo[0] = '0;
	assign dv_pay[0] = dvp_s7;

	for (genvar k = 0; k < NW; k++) begin : g_div
		stage_ctl_t ctl;
		assign ctl.en    = en;
		assign ctl.valid = dv_v[k];

		rgps_div_cell #(
			.NW   (NW),
			.DVW  (DVW),
			.PAYW (DVPW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_i   (ctl),
			.num_i   (dv_num[k]),
			.den_i   (dv_den[k]),
			.rem_i   (dv_rem[k]),
			.quo_i   (dv_quo[k]),
			.pay_i   (dv_pay[k]),
			.valid_o (dv_v[k+1]),
			.num_o   (dv_num[k+1]),
			.den_o   (dv_den[k+1]),
			.rem_o   (dv_rem[k+1]),
			.quo_o   (dv_quo[k+1]),
			.pay_o   (dv_pay[k+1])
		);
	end

	// ---------------------------------------------------------------- s8: signed roots
	dvp_t                 dvo;
	logic signed [RTW-1:0] root_s8 [2];
	logic                  lin_s8, dead_s8, inside_s8;

	assign dvo = dvp_t'(dv_pay[NW]);

	always_ff @(posedge clk) begin
		if (en) begin
			root_s8[0] <= dvo.neg0 ? -$signed({1'b0, dv_quo[NW][0]}) : $signed({1'b0, dv_quo[NW][0]});
			root_s8[1] <= dvo.neg1 ? -$signed({1'b0, dv_quo[NW][1]}) : $signed({1'b0, dv_quo[NW][1]});
			lin_s8     <= dvo.lin;
			dead_s8    <= dvo.dead;
			inside_s8  <= dvo.in_end;
		end
	end

	// ---------------------------------------------------------------- s9: per-root classification
	logic                  win_n  [2];
	logic                  elig_n [2];
	logic [FRAC_BITS:0]    tcl_n  [2];
	logic signed [RTW-1:0] dist_n [2];
	logic [C-1:0]          sat_n  [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			logic rneg, rgt, ebf, eaf;
			rneg = root_s8[l][RTW-1];
			rgt  = (root_s8[l] > UNIT_R);
			ebf  = rneg && eb_q;
			eaf  = rgt && ea_q;
			win_n[l]  = (root_s8[l] >= LO_R) && (root_s8[l] <= HI_R);
			elig_n[l] = ebf || eaf;
			// only one root in the near-linear case
			if (l == 1 && lin_s8) begin
				win_n[l]  = 1'b0;
				elig_n[l] = 1'b0;
			end
			tcl_n[l]  = rneg ? '0 : (rgt ? UNIT_R[FRAC_BITS:0] : root_s8[l][FRAC_BITS:0]);
			dist_n[l] = ebf ? -root_s8[l] : (root_s8[l] - UNIT_R);
			if (root_s8[l] > LIMHI_R) begin
				sat_n[l] = {1'b0, {(C-1){1'b1}}};
			end else if (root_s8[l] < LIMLO_R) begin
				sat_n[l] = {1'b1, {(C-1){1'b0}}};
			end else begin
				sat_n[l] = root_s8[l][C-1:0];
			end
		end
	end

	logic                  win_s9  [2];
	logic                  elig_s9 [2];
	logic [FRAC_BITS:0]    tcl_s9  [2];
	logic signed [RTW-1:0] dist_s9 [2];
	logic [C-1:0]          sat_s9  [2];
	logic                  dead_s9, inside_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				win_s9[l]  <= win_n[l];
				elig_s9[l] <= elig_n[l];
				tcl_s9[l]  <= tcl_n[l];
				dist_s9[l] <= dist_n[l];
				sat_s9[l]  <= sat_n[l];
			end
			dead_s9   <= dead_s8;
			inside_s9 <= inside_s8;
		end
	end

	// ---------------------------------------------------------------- final pick
	logic [C-1:0] pick_t;
	logic         pick_hit;
	logic [FRAC_BITS:0] tmax;

	always_comb begin
		pick_t   = '0;
		pick_hit = 1'b0;
		if (win_s9[0] && win_s9[1]) begin
			tmax = (tcl_s9[1] > tcl_s9[0]) ? tcl_s9[1] : tcl_s9[0];
		end else begin
			tmax = win_s9[0] ? tcl_s9[0] : tcl_s9[1];
		end
		if (dead_s9) begin
			pick_hit = 1'b0;
		end else if (win_s9[0] || win_s9[1]) begin
			pick_t   = C'(tmax);
			pick_hit = 1'b1;
		end else if (inside_s9) begin
			pick_t   = C'(1) << FRAC_BITS;
			pick_hit = 1'b1;
		end else if (elig_s9[0] && elig_s9[1]) begin
			// tie keeps the first root
			pick_t   = (dist_s9[1] < dist_s9[0]) ? sat_s9[1] : sat_s9[0];
			pick_hit = 1'b1;
		end else if (elig_s9[0]) begin
			pick_t   = sat_s9[0];
			pick_hit = 1'b1;
		end else if (elig_s9[1]) begin
			pick_t   = sat_s9[1];
			pick_hit = 1'b1;
		end
	end

	// ---------------------------------------------------------------- two-entry output buffer
	logic [C-1:0] ob_t_q   [2];
	logic         ob_hit_q [2];
	logic         wr_ptr_q, rd_ptr_q;

	assign push = en && v_s9;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ob_t_q[wr_ptr_q]   <= pick_t;
			ob_hit_q[wr_ptr_q] <= pick_hit;
		end
	end

	assign result.valid   = (cnt_q != 2'd0);
	assign result.t_value = ob_t_q[rd_ptr_q];
	assign result.hit     = ob_hit_q[rd_ptr_q];

`ifndef SYNTHESIS
	// buffer never holds more than two beats
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output buffer overflow");

	// a full buffer with no taker stalls the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !result.ready) |-> !point.ready)
		else $error("input taken while output buffer full");

	// a miss always carries a zero parameter
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.hit) |-> (result.t_value == '0))
		else $error("nonzero t on a miss");

	// a pushed beat shows up at the output on the next cycle
	a_push_vis: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> result.valid)
		else $error("pushed beat not visible");
`endif

endmodule

`default_nettype wire
